[design/abst_pkg.sv]
`default_nettype none

package abst_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int LEN_W    = 16;
    localparam int OPCODE_W = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // ethernet header plus arp body
    localparam logic [LEN_W-1:0]    MIN_FRAME_LEN = LEN_W'(14 + 28);
    localparam logic [OPCODE_W-1:0] OPCODE_REPLY  = OPCODE_W'(2);

    // cells per registered reduction group
    localparam int REDUCE_GROUP = 16;

    localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_SPOOF     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_EVICTED   = 3'd5;

    typedef struct packed {
        logic shift;
        logic write_ip;
        logic write_mac;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/abst_cell.sv]
`default_nettype none

module abst_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  wire logic                       clk,
    input  wire abst_pkg::cell_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0]           wr_pos,
    input  wire logic [abst_pkg::IP_W-1:0]  wr_ip,
    input  wire logic [abst_pkg::MAC_W-1:0] wr_mac,
    input  wire logic [abst_pkg::IP_W-1:0]  next_ip,
    input  wire logic [abst_pkg::MAC_W-1:0] next_mac,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic [abst_pkg::IP_W-1:0]  query_ip,
    output logic [abst_pkg::IP_W-1:0]       ip,
    output logic [abst_pkg::MAC_W-1:0]      mac,
    output logic                            match
);
    import abst_pkg::*;

    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             match_reg;
    logic             sel;
    logic             occupied;

    assign sel      = (wr_pos == IDX_W'(IDX));
    assign occupied = (CNT_W'(IDX) < count);

    always_ff @(posedge clk)
    begin
        if (ctrl.write_ip && sel)
        begin
            ip_reg <= wr_ip;
        end
        else if (ctrl.shift)
        begin
            ip_reg <= next_ip;
        end

        if (ctrl.write_mac && sel)
        begin
            mac_reg <= wr_mac;
        end
        else if (ctrl.shift)
        begin
            mac_reg <= next_mac;
        end

        // only entries below the fill count take part in the search
        match_reg <= occupied && (ip_reg == query_ip);
    end

    assign ip    = ip_reg;
    assign mac   = mac_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

[design/abst_reduce.sv]
`default_nettype none

module abst_reduce #(
    parameter int GROUP = 16,
    parameter int BASE  = 0,
    parameter int IDX_W = 6
) (
    input  wire logic                                  clk,
    input  wire logic [GROUP-1:0]                      match,
    input  wire logic [GROUP-1:0][abst_pkg::MAC_W-1:0] mac,
    output logic                                       hit,
    output logic [IDX_W-1:0]                           pos,
    output logic [abst_pkg::MAC_W-1:0]                 hit_mac
);
    import abst_pkg::*;

    logic             hit_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             hit_next;
    logic [IDX_W-1:0] pos_next;
    logic [MAC_W-1:0] mac_next;

    // at most one match in the table, so an or of gated values selects it
    always_comb
    begin
        hit_next = 1'b0;
        pos_next = '0;
        mac_next = '0;
        for (int k = 0; k < GROUP; k++)
        begin
            if (match[k])
            begin
                hit_next = 1'b1;
                pos_next = pos_next | IDX_W'(BASE + k);
                mac_next = mac_next | mac[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        pos_reg <= pos_next;
        mac_reg <= mac_next;
    end

    assign hit     = hit_reg;
    assign pos     = pos_reg;
    assign hit_mac = mac_reg;

endmodule

`default_nettype wire

[design/arp_binding_table_spoof_check_core.sv]
`default_nettype none

// arp reply binding table with spoof detection. a record is taken when start is
// high and busy is low; exactly one result follows, shown for a single cycle
// with done high, and the receiver cannot stall it. records that are too short
// (under 42 bytes) or are not replies give their result in the cycle after the
// transaction. replies take these steps: the query is registered, every cell
// compares its entry in parallel, the match lines are reduced in a registered
// group stage, and the final combine decides and updates the table, with the
// result registered. the table is a chain of TABLE_DEPTH cells kept in
// age order (cell 0 oldest); eviction shifts every cell one place towards
// cell 0. no clearing pass after reset: only cells below the fill count are
// ever compared, so the block is ready straight out of reset.
module arp_binding_table_spoof_check_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [abst_pkg::LEN_W-1:0]          frame_len,
    input  wire logic [abst_pkg::OPCODE_W-1:0]       arp_opcode,
    input  wire logic [abst_pkg::IP_W-1:0]           src_ip,
    input  wire logic [abst_pkg::MAC_W-1:0]          src_mac,
    output logic                                     done,
    output logic [abst_pkg::STATUS_W-1:0]            status,
    output logic [abst_pkg::POS_W-1:0]               entry_position,
    output logic [abst_pkg::COUNT_W-1:0]             entry_count,
    output logic [abst_pkg::MAC_W-1:0]               previous_mac,
    output logic [abst_pkg::IP_W-1:0]                evicted_ip
);
    import abst_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int NGROUPS = (TABLE_DEPTH + REDUCE_GROUP - 1) / REDUCE_GROUP;
    localparam int PAD     = NGROUPS * REDUCE_GROUP;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;
    localparam logic [1:0] S_DEC  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;

    // query registers, loaded on each accepted transaction
    logic [IP_W-1:0]  query_ip_reg;
    logic [MAC_W-1:0] query_mac_reg;

    // result registers
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    rcount_reg, rcount_next;
    logic [MAC_W-1:0]    prev_mac_reg, prev_mac_next;
    logic [IP_W-1:0]     evict_ip_reg, evict_ip_next;

    logic accept;
    logic short_frame;
    logic not_reply;

    // cell chain
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] wr_pos;
    logic [IP_W-1:0]  cell_ip  [TABLE_DEPTH];
    logic [MAC_W-1:0] cell_mac [TABLE_DEPTH];
    logic             cell_match [TABLE_DEPTH];

    // reduction
    logic [PAD-1:0]            pad_match;
    logic [PAD-1:0][MAC_W-1:0] pad_mac;
    logic                      grp_hit [NGROUPS];
    logic [IDX_W-1:0]          grp_pos [NGROUPS];
    logic [MAC_W-1:0]          grp_mac [NGROUPS];
    logic                      found;
    logic [IDX_W-1:0]          found_pos;
    logic [MAC_W-1:0]          found_mac;
    logic                      full;

    // result field widening, taken modulo the field width
    logic [IDX_W+POS_W-1:0]   pos_ext;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign short_frame = (frame_len < MIN_FRAME_LEN);
    assign not_reply   = (arp_opcode != OPCODE_REPLY);
    assign full        = (count_reg == CNT_W'(TABLE_DEPTH));

    // chain of entry cells, each takes its younger neighbour on a shift
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [IP_W-1:0]  nb_ip;
        logic [MAC_W-1:0] nb_mac;

        if (i < TABLE_DEPTH - 1)
        begin : g_nb
            assign nb_ip  = cell_ip[i+1];
            assign nb_mac = cell_mac[i+1];
        end
        else
        begin : g_last
            // youngest cell is always rewritten on an eviction
            assign nb_ip  = cell_ip[i];
            assign nb_mac = cell_mac[i];
        end

        abst_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .wr_pos   (wr_pos),
            .wr_ip    (query_ip_reg),
            .wr_mac   (query_mac_reg),
            .next_ip  (nb_ip),
            .next_mac (nb_mac),
            .count    (count_reg),
            .query_ip (query_ip_reg),
            .ip       (cell_ip[i]),
            .mac      (cell_mac[i]),
            .match    (cell_match[i])
        );
    end

    // pad the match lines up to a whole number of groups
    for (genvar j = 0; j < PAD; j++)
    begin : g_pad
        if (j < TABLE_DEPTH)
        begin : g_real
            assign pad_match[j] = cell_match[j];
            assign pad_mac[j]   = cell_mac[j];
        end
        else
        begin : g_fill
            assign pad_match[j] = 1'b0;
            assign pad_mac[j]   = '0;
        end
    end

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_grp
        abst_reduce #(
            .GROUP (REDUCE_GROUP),
            .BASE  (g * REDUCE_GROUP),
            .IDX_W (IDX_W)
        ) u_reduce (
            .clk     (clk),
            .match   (pad_match[g*REDUCE_GROUP +: REDUCE_GROUP]),
            .mac     (pad_mac[g*REDUCE_GROUP +: REDUCE_GROUP]),
            .hit     (grp_hit[g]),
            .pos     (grp_pos[g]),
            .hit_mac (grp_mac[g])
        );
    end

    // final combine across groups, at most one group reports a hit
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        found_mac = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            found     = found | grp_hit[g];
            found_pos = found_pos | grp_pos[g];
            found_mac = found_mac | grp_mac[g];
        end
    end

    // sequencer, table update and result selection
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        pos_next      = pos_reg;
        rcount_next   = rcount_reg;
        prev_mac_next = prev_mac_reg;
        evict_ip_next = evict_ip_reg;
        ctrl          = '0;
        wr_pos        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (short_frame)
                    begin
                        done_next     = 1'b1;
                        status_next   = STATUS_SHORT;
                        pos_next      = '0;
                        rcount_next   = count_reg;
                        prev_mac_next = '0;
                        evict_ip_next = '0;
                    end
                    else if (not_reply)
                    begin
                        done_next     = 1'b1;
                        status_next   = STATUS_IGNORED;
                        pos_next      = '0;
                        rcount_next   = count_reg;
                        prev_mac_next = '0;
                        evict_ip_next = '0;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                prev_mac_next = '0;
                evict_ip_next = '0;
                priority if (found)
                begin
                    // known binding: rewrite the mac in place
                    ctrl.write_mac = 1'b1;
                    wr_pos         = found_pos;
                    pos_next       = found_pos;
                    rcount_next    = count_reg;
                    if (found_mac != query_mac_reg)
                    begin
                        status_next   = STATUS_SPOOF;
                        prev_mac_next = found_mac;
                    end
                    else
                    begin
                        status_next = STATUS_REFRESHED;
                    end
                end
                else if (full)
                begin
                    // drop the oldest, shift the chain, append at the young end
                    ctrl.shift     = 1'b1;
                    ctrl.write_ip  = 1'b1;
                    ctrl.write_mac = 1'b1;
                    wr_pos         = IDX_W'(TABLE_DEPTH - 1);
                    pos_next       = IDX_W'(TABLE_DEPTH - 1);
                    rcount_next    = count_reg;
                    status_next    = STATUS_EVICTED;
                    evict_ip_next  = cell_ip[0];
                end
                else
                begin
                    ctrl.write_ip  = 1'b1;
                    ctrl.write_mac = 1'b1;
                    wr_pos         = count_reg[IDX_W-1:0];
                    pos_next       = count_reg[IDX_W-1:0];
                    count_next     = count_reg + CNT_W'(1);
                    rcount_next    = count_reg + CNT_W'(1);
                    status_next    = STATUS_ADDED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_ip_reg  <= src_ip;
            query_mac_reg <= src_mac;
        end
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        rcount_reg   <= rcount_next;
        prev_mac_reg <= prev_mac_next;
        evict_ip_reg <= evict_ip_next;
    end

    assign pos_ext = {{POS_W{1'b0}}, pos_reg};
    assign cnt_ext = {{COUNT_W{1'b0}}, rcount_reg};

    assign done           = done_reg;
    assign status         = status_reg;
    assign entry_position = pos_ext[POS_W-1:0];
    assign entry_count    = cnt_ext[COUNT_W-1:0];
    assign previous_mac   = prev_mac_reg;
    assign evicted_ip     = evict_ip_reg;

endmodule

`default_nettype wire
